// ----- rtl/core/gmig_pkg.sv -----
// ----------------------------------------------------------------------------
// gmig_pkg
// Shared types, codes and step tables of the grid mesh index generator.
// ----------------------------------------------------------------------------
package gmig_pkg;

  localparam int unsigned ResBitsDef = 10;
  localparam int unsigned IdxW       = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned StepW      = 4;
  localparam int unsigned DqDepth    = 2;
  localparam int unsigned OutDepth   = 4;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMode   = 2'd2;

  typedef enum logic [1:0] {
    ModeQuad    = 2'd0,
    ModeTri     = 2'd1,
    ModeBezier  = 2'd2,
    ModeUnused  = 2'd3
  } mode_e;

  // offset codes: neighbour offsets -1, 0, +1, +2
  localparam logic [1:0] OffM1 = 2'd0;
  localparam logic [1:0] Off0  = 2'd1;
  localparam logic [1:0] OffP1 = 2'd2;
  localparam logic [1:0] OffP2 = 2'd3;

  typedef struct packed {
    logic  bad;
    mode_e mode;
  } cell_ctl_t;

  typedef struct packed {
    logic last;
    logic bad;
  } res_flags_t;

  // {row offset code, column offset code} for step k
  function automatic logic [3:0] step_offs(mode_e mode, logic [StepW-1:0] k);
    logic [3:0] offs;
    offs = {Off0, Off0};
    case (mode)
      ModeQuad: begin
        case (k)
          4'd1:    offs = {Off0, OffP1};
          4'd2:    offs = {OffP1, Off0};
          4'd3:    offs = {OffP1, OffP1};
          default: offs = {Off0, Off0};
        endcase
      end
      ModeTri: begin
        case (k)
          4'd1, 4'd3: offs = {OffP1, Off0};
          4'd2, 4'd5: offs = {Off0, OffP1};
          4'd4:       offs = {OffP1, OffP1};
          default:    offs = {Off0, Off0};
        endcase
      end
      ModeBezier: offs = k;
      default:    offs = {Off0, Off0};
    endcase
    return offs;
  endfunction

  function automatic logic step_last(cell_ctl_t ctl, logic [StepW-1:0] k);
    logic last;
    if (ctl.bad) begin
      last = 1'b1;
    end else begin
      case (ctl.mode)
        ModeQuad:   last = (k == 4'd3);
        ModeTri:    last = (k == 4'd5);
        ModeBezier: last = (k == 4'd15);
        default:    last = 1'b1;
      endcase
    end
    return last;
  endfunction

endpackage

// ----- rtl/core/gmig_front.sv -----
// ----------------------------------------------------------------------------
// gmig_front
// Configuration registers, cell classification and the cell queue that
// decouples intake from index generation.
// ----------------------------------------------------------------------------
module gmig_front #(
  parameter int unsigned RES_BITS = gmig_pkg::ResBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gmig_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [RES_BITS-1:0]          cfg_data_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [RES_BITS-1:0]          cell_col_i,
  input  logic [RES_BITS-1:0]          cell_row_i,
  output logic [RES_BITS-1:0]          width_o,
  output logic [RES_BITS-1:0]          height_o,
  output logic                         cq_valid_o,
  output logic [RES_BITS-1:0]          cq_col_o,
  output logic [RES_BITS-1:0]          cq_row_o,
  output gmig_pkg::cell_ctl_t          cq_ctl_o,
  input  logic                         cq_pop_i
);
  import gmig_pkg::*;

  localparam int unsigned PtrW = $clog2(DqDepth);
  localparam int unsigned CntW = $clog2(DqDepth + 1);

  logic [RES_BITS-1:0] width_q, height_q;
  mode_e               mode_q;

  logic [RES_BITS-1:0] col_mem [DqDepth];
  logic [RES_BITS-1:0] row_mem [DqDepth];
  cell_ctl_t           ctl_mem [DqDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic      accept, enq;
  cell_ctl_t ctl_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RES_BITS'(1);
      height_q <= RES_BITS'(1);
      mode_q   <= ModeQuad;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        CfgMode:   mode_q   <= mode_e'(cfg_data_i[1:0]);
        default:   ;
      endcase
    end
  end

  assign full_o = (cnt_q == CntW'(DqDepth));
  assign accept = push_i && !full_o;

  // zero-sized grids fall out of the compares: nothing is below zero
  assign ctl_in.bad  = (cell_col_i >= width_q) || (cell_row_i >= height_q);
  assign ctl_in.mode = mode_q;
  // unused mode on a good cell yields nothing, so it is never queued
  assign enq = accept && (ctl_in.bad || (mode_q != ModeUnused));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cq_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({enq, cq_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      col_mem[wr_ptr_q] <= cell_col_i;
      row_mem[wr_ptr_q] <= cell_row_i;
      ctl_mem[wr_ptr_q] <= ctl_in;
    end
  end

  assign width_o    = width_q;
  assign height_o   = height_q;
  assign cq_valid_o = (cnt_q != '0);
  assign cq_col_o   = col_mem[rd_ptr_q];
  assign cq_row_o   = row_mem[rd_ptr_q];
  assign cq_ctl_o   = ctl_mem[rd_ptr_q];

endmodule

// ----- rtl/core/gmig_back.sv -----
// ----------------------------------------------------------------------------
// gmig_back
// Step sequencer: walks the queued cell one vertex per cycle and registers
// the clamped vertex row and column.
// ----------------------------------------------------------------------------
module gmig_back #(
  parameter int unsigned RES_BITS = gmig_pkg::ResBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RES_BITS-1:0]  width_i,
  input  logic [RES_BITS-1:0]  height_i,
  input  logic                 cq_valid_i,
  input  logic [RES_BITS-1:0]  cq_col_i,
  input  logic [RES_BITS-1:0]  cq_row_i,
  input  gmig_pkg::cell_ctl_t  cq_ctl_i,
  output logic                 cq_pop_o,
  input  logic                 room_i,
  output logic                 vtx_valid_o,
  output logic [RES_BITS-1:0]  vtx_row_o,
  output logic [RES_BITS-1:0]  vtx_col_o,
  output gmig_pkg::res_flags_t vtx_flags_o
);
  import gmig_pkg::*;

  function automatic logic [RES_BITS-1:0] clamp_off(logic [RES_BITS-1:0] base,
                                                    logic [1:0]          code,
                                                    logic [RES_BITS-1:0] top);
    logic [RES_BITS:0]   sum;
    logic [RES_BITS-1:0] res;
    sum = {1'b0, base} + (RES_BITS + 1)'(code) - (RES_BITS + 1)'(1);
    if (code == OffM1) begin
      res = (base == '0) ? '0 : base - 1'b1;
    end else if (sum > {1'b0, top}) begin
      res = top;
    end else begin
      res = sum[RES_BITS-1:0];
    end
    return res;
  endfunction

  logic [StepW-1:0]    k_q, k_d;
  logic                issue, last;
  logic [3:0]          offs;
  logic [RES_BITS-1:0] row_c, col_c;

  logic                 v_q;
  logic [RES_BITS-1:0]  row_q, col_q;
  res_flags_t           flags_q;

  assign issue = cq_valid_i && room_i;
  assign last  = step_last(cq_ctl_i, k_q);
  assign offs  = step_offs(cq_ctl_i.mode, k_q);

  always_comb begin
    if (cq_ctl_i.bad) begin
      row_c = '0;
      col_c = '0;
    end else begin
      row_c = clamp_off(cq_row_i, offs[3:2], height_i);
      col_c = clamp_off(cq_col_i, offs[1:0], width_i);
    end
  end

  always_comb begin
    k_d = k_q;
    if (issue) begin
      k_d = last ? '0 : k_q + 1'b1;
    end
  end

  assign cq_pop_o = issue && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      v_q <= 1'b0;
    end else begin
      k_q <= k_d;
      v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      row_q        <= row_c;
      col_q        <= col_c;
      flags_q.last <= last;
      flags_q.bad  <= cq_ctl_i.bad;
    end
  end

  assign vtx_valid_o = v_q;
  assign vtx_row_o   = row_q;
  assign vtx_col_o   = col_q;
  assign vtx_flags_o = flags_q;

endmodule

// ----- rtl/core/gmig_outq.sv -----
// ----------------------------------------------------------------------------
// gmig_outq
// Row-major index multiply-add and the result queue. Space is reserved for
// the vertex in flight, so the sequencer never overruns the queue.
// ----------------------------------------------------------------------------
module gmig_outq #(
  parameter int unsigned RES_BITS = gmig_pkg::ResBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [RES_BITS-1:0]         width_i,
  input  logic                        vtx_valid_i,
  input  logic [RES_BITS-1:0]         vtx_row_i,
  input  logic [RES_BITS-1:0]         vtx_col_i,
  input  gmig_pkg::res_flags_t        vtx_flags_i,
  output logic                        room_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [gmig_pkg::IdxW-1:0]   vertex_index_o,
  output logic                        last_of_cell_o,
  output logic                        bad_cell_o
);
  import gmig_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam int unsigned PW   = 2 * RES_BITS + 1;
  localparam int unsigned EW   = (PW > IdxW) ? PW : IdxW;

  logic [IdxW-1:0] idx_mem   [OutDepth];
  res_flags_t      flags_mem [OutDepth];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd;

  logic [RES_BITS:0] pitch;
  logic [PW-1:0]     lin;
  logic [EW-1:0]     lin_ext;

  assign pitch   = {1'b0, width_i} + 1'b1;
  assign lin     = PW'(vtx_row_i) * PW'(pitch) + PW'(vtx_col_i);
  assign lin_ext = EW'(lin);

  assign empty_o = (cnt_q == '0);
  assign rd      = pop_i && !empty_o;
  assign room_o  = ((CntW + 1)'(cnt_q) + (CntW + 1)'(vtx_valid_i)) < (CntW + 1)'(OutDepth);

  always_comb begin
    case ({vtx_valid_i, rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (vtx_valid_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_valid_i) begin
      idx_mem[wr_ptr_q]   <= lin_ext[IdxW-1:0];
      flags_mem[wr_ptr_q] <= vtx_flags_i;
    end
  end

  assign vertex_index_o = idx_mem[rd_ptr_q];
  assign last_of_cell_o = flags_mem[rd_ptr_q].last;
  assign bad_cell_o     = flags_mem[rd_ptr_q].bad;

endmodule

// ----- rtl/core/grid_mesh_index_generator.sv -----
// ----------------------------------------------------------------------------
// grid_mesh_index_generator
// Emits the row-major vertex indices of one grid cell per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Cells enter through a queue-style port: a transfer happens when push_i
//   is high and full_o low. Indices leave through a second queue: while
//   empty_o is low the oldest index is on the result ports, and pop_i takes
//   it. last_of_cell_o marks the final index of a cell; a cell outside the
//   grid gives a single index of zero with bad_cell_o set.
//   Configuration (width, height, mode) is written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while the block is idle.
//   A cell passes the cell queue and the vertex register into the result queue.
//   Throughput: one index per cycle while the result queue has room, set by
//   the step sequencer and the single multiply-add; a cell gives 4 (quad),
//   6 (triangles), 16 (smooth bezier) or 1 (outside the grid) indices. A
//   two-entry cell queue lets new cells enter while earlier ones are being
//   expanded.
//   Reset empties both queues and loads a 1 x 1 grid in quad mode.
//   A stalled receiver fills the four-entry result queue; the sequencer
//   then halts and the cell queue backs up into full_o.
// ----------------------------------------------------------------------------
module grid_mesh_index_generator #(
  parameter int unsigned RES_BITS = gmig_pkg::ResBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gmig_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [RES_BITS-1:0]         cfg_data_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [RES_BITS-1:0]         cell_col_i,
  input  logic [RES_BITS-1:0]         cell_row_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [gmig_pkg::IdxW-1:0]   vertex_index_o,
  output logic                        last_of_cell_o,
  output logic                        bad_cell_o
);
  import gmig_pkg::*;

  logic [RES_BITS-1:0] width, height;
  logic                cq_valid, cq_pop;
  logic [RES_BITS-1:0] cq_col, cq_row;
  cell_ctl_t           cq_ctl;
  logic                room, vtx_valid;
  logic [RES_BITS-1:0] vtx_row, vtx_col;
  res_flags_t          vtx_flags;

  gmig_front #(.RES_BITS(RES_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .cell_col_i (cell_col_i),
    .cell_row_i (cell_row_i),
    .width_o    (width),
    .height_o   (height),
    .cq_valid_o (cq_valid),
    .cq_col_o   (cq_col),
    .cq_row_o   (cq_row),
    .cq_ctl_o   (cq_ctl),
    .cq_pop_i   (cq_pop)
  );

  gmig_back #(.RES_BITS(RES_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width),
    .height_i    (height),
    .cq_valid_i  (cq_valid),
    .cq_col_i    (cq_col),
    .cq_row_i    (cq_row),
    .cq_ctl_i    (cq_ctl),
    .cq_pop_o    (cq_pop),
    .room_i      (room),
    .vtx_valid_o (vtx_valid),
    .vtx_row_o   (vtx_row),
    .vtx_col_o   (vtx_col),
    .vtx_flags_o (vtx_flags)
  );

  gmig_outq #(.RES_BITS(RES_BITS)) u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width),
    .vtx_valid_i    (vtx_valid),
    .vtx_row_i      (vtx_row),
    .vtx_col_i      (vtx_col),
    .vtx_flags_i    (vtx_flags),
    .room_o         (room),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .vertex_index_o (vertex_index_o),
    .last_of_cell_o (last_of_cell_o),
    .bad_cell_o     (bad_cell_o)
  );

endmodule

// ----- tb/sv/gmig_index_check.sv -----
// ----------------------------------------------------------------------------
// gmig_index_check
// Watches the cell, result and register ports of the grid mesh index
// generator, works out the vertex indices due for every accepted cell and
// compares each result transfer against the oldest one still due.
// ----------------------------------------------------------------------------
module gmig_index_check #(
  parameter int unsigned RES_BITS = gmig_pkg::ResBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gmig_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [RES_BITS-1:0]          cfg_data_i,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [RES_BITS-1:0]          cell_col_i,
  input  logic [RES_BITS-1:0]          cell_row_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [gmig_pkg::IdxW-1:0]    vertex_index_i,
  input  logic                         last_of_cell_i,
  input  logic                         bad_cell_i,
  output int unsigned                  due_count_o,
  output int unsigned                  mismatch_count_o
);
  import gmig_pkg::*;

  typedef struct {
    logic [IdxW-1:0] vidx;
    logic            last;
    logic            bad;
  } vertex_due_t;

  vertex_due_t index_due[$];
  vertex_due_t oldest;
  int unsigned grid_w = 1;
  int unsigned grid_h = 1;
  mode_e       grid_mode = ModeQuad;
  int unsigned mismatches = 0;

  function automatic int unsigned clamp_coord(int unsigned base, int off, int unsigned top);
    int unsigned moved;
    if (off < 0) begin
      return (base == 0) ? 0 : base - 1;
    end
    moved = base + off;
    return (moved > top) ? top : moved;
  endfunction

  function automatic void due_vertex(int unsigned row, int unsigned col, logic last);
    vertex_due_t v;
    v.vidx = IdxW'(row * (grid_w + 1) + col);
    v.last = last;
    v.bad  = 1'b0;
    index_due.insert(index_due.size(), v);
  endfunction

  // Indices that one cell gives under the current register settings
  function automatic void expand_cell(int unsigned c, int unsigned r);
    vertex_due_t v;
    int dy;
    int dx;
    if (c >= grid_w || r >= grid_h) begin
      v.vidx = '0;
      v.last = 1'b1;
      v.bad  = 1'b1;
      index_due.insert(index_due.size(), v);
      return;
    end
    case (grid_mode)
      ModeQuad: begin
        due_vertex(r, c, 1'b0);
        due_vertex(r, c + 1, 1'b0);
        due_vertex(r + 1, c, 1'b0);
        due_vertex(r + 1, c + 1, 1'b1);
      end
      ModeTri: begin
        due_vertex(r, c, 1'b0);
        due_vertex(r + 1, c, 1'b0);
        due_vertex(r, c + 1, 1'b0);
        due_vertex(r + 1, c, 1'b0);
        due_vertex(r + 1, c + 1, 1'b0);
        due_vertex(r, c + 1, 1'b1);
      end
      ModeBezier: begin
        for (dy = -1; dy <= 2; dy++) begin
          for (dx = -1; dx <= 2; dx++) begin
            due_vertex(clamp_coord(r, dy, grid_h), clamp_coord(c, dx, grid_w),
                       (dy == 2 && dx == 2));
          end
        end
      end
      default: ; // unused mode: nothing for a cell inside the grid
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w    = 1;
      grid_h    = 1;
      grid_mode = ModeQuad;
      index_due.delete();
      due_count_o      <= 0;
      mismatch_count_o <= 0;
    end else begin
      // result first: a cell accepted on this edge cannot have a result out yet
      if (pop_i && !empty_i) begin
        if (index_due.size() == 0) begin
          $error("unexpected result: vertex_index %0d last_of_cell %0b bad_cell %0b",
                 vertex_index_i, last_of_cell_i, bad_cell_i);
          mismatches++;
        end else begin
          oldest = index_due.pop_front();
          if (vertex_index_i !== oldest.vidx) begin
            $error("vertex_index: expected %0d, got %0d", oldest.vidx, vertex_index_i);
            mismatches++;
          end
          if (last_of_cell_i !== oldest.last) begin
            $error("last_of_cell: expected %0b, got %0b", oldest.last, last_of_cell_i);
            mismatches++;
          end
          if (bad_cell_i !== oldest.bad) begin
            $error("bad_cell: expected %0b, got %0b", oldest.bad, bad_cell_i);
            mismatches++;
          end
        end
      end
      if (push_i && !full_i) begin
        expand_cell(cell_col_i, cell_row_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWidth:  grid_w = cfg_data_i;
          CfgHeight: grid_h = cfg_data_i;
          CfgMode:   grid_mode = mode_e'(cfg_data_i[1:0]);
          default:   ;
        endcase
      end
      due_count_o      <= index_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives cells and register settings into the grid mesh index generator
// with random gaps and receiver stalls, and reports the verdict of the
// index checker that sits beside it.
// ----------------------------------------------------------------------------
module testbench;
  import gmig_pkg::*;

  localparam int unsigned ResBits      = ResBitsDef;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned RandomItems  = 440;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [ResBits-1:0]  cfg_data_i;
  logic                push_i;
  logic                full_o;
  logic [ResBits-1:0]  cell_col_i;
  logic [ResBits-1:0]  cell_row_i;
  logic                empty_o;
  logic                pop_i;
  logic [IdxW-1:0]     vertex_index_o;
  logic                last_of_cell_o;
  logic                bad_cell_o;

  int unsigned due_count;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;

  int unsigned cur_w = 1;
  int unsigned cur_h = 1;
  mode_e       cur_mode = ModeQuad;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned hold_asks = 0;

  grid_mesh_index_generator #(.RES_BITS(ResBits)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .vertex_index_o (vertex_index_o),
    .last_of_cell_o (last_of_cell_o),
    .bad_cell_o     (bad_cell_o)
  );

  gmig_index_check #(.RES_BITS(ResBits)) index_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push_i),
    .full_i           (full_o),
    .cell_col_i       (cell_col_i),
    .cell_row_i       (cell_row_i),
    .empty_i          (empty_o),
    .pop_i            (pop_i),
    .vertex_index_i   (vertex_index_o),
    .last_of_cell_i   (last_of_cell_o),
    .bad_cell_i       (bad_cell_o),
    .due_count_o      (due_count),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int unsigned pick_extent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return $urandom_range(1, 6);
    if (pick < 75) return $urandom_range(7, 64);
    if (pick < 90) return $urandom_range(65, 1023);
    if (pick < 96) return 1023;
    return 0;
  endfunction

  // Result side: random stalls, plus a long hold whenever one is asked for
  initial begin
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    pop_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        stall_left = RxHoldCycles;
      end
      if (stall_left > 0) begin
        pop_i <= 1'b0;
        stall_left--;
      end else begin
        pop_i <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Stop offering cells and wait until every due index has come out
  task automatic settle();
    push_i <= 1'b0;
    while (due_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= ResBits'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h, input mode_e m);
    settle();
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
    write_reg(CfgMode, int'(m));
    cur_w    = w;
    cur_h    = h;
    cur_mode = m;
  endtask

  task automatic send_cell(input int unsigned col, input int unsigned row);
    int unsigned gap;
    gap = tx_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      push_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push_i     <= 1'b1;
    cell_col_i <= ResBits'(col);
    cell_row_i <= ResBits'(row);
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned fed;
    int unsigned n;
    int unsigned col;
    int unsigned row;
    int unsigned pick;
    mode_e       m;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgWidth;
    cfg_data_i = '0;
    push_i     = 1'b0;
    cell_col_i = '0;
    cell_row_i = '0;
    fed        = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset grid is 1 x 1 in quad mode
    rx_idle_on = 1'b1;
    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(0, 1);
    send_cell(1023, 1023);

    set_grid(1023, 1023, ModeTri);
    send_cell(1022, 1022);
    send_cell(0, 0);
    send_cell(1023, 5);

    set_grid(1023, 1023, ModeBezier);
    send_cell(0, 0);
    send_cell(1022, 1022);
    send_cell(1022, 0);
    send_cell(511, 512);

    // neighbourhood clamped on every side
    set_grid(1, 1, ModeBezier);
    send_cell(0, 0);

    set_grid(3, 2, ModeQuad);
    send_cell(2, 1);
    send_cell(3, 0);
    send_cell(0, 2);

    set_grid(4, 4, ModeUnused);
    send_cell(1, 1);
    send_cell(4, 0);

    // zero-sized grid: everything lies outside
    set_grid(0, 5, ModeQuad);
    send_cell(0, 0);
    set_grid(5, 0, ModeTri);
    send_cell(0, 0);

    // back-pressure: receiver holds off while cells keep coming
    set_grid(1023, 1023, ModeBezier);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_asks++;
    repeat (12) send_cell($urandom_range(0, 1022), $urandom_range(0, 1022));

    while (fed < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) m = ModeQuad;
      else if (pick < 55) m = ModeTri;
      else if (pick < 90) m = ModeBezier;
      else m = ModeUnused;
      set_grid(pick_extent(), pick_extent(), m);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 50);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (cur_w != 0 && cur_h != 0 && pick < 85) begin
          col = $urandom_range(0, cur_w - 1);
          row = $urandom_range(0, cur_h - 1);
        end else if (pick < 90) begin
          // just past the right edge, at times also past the bottom one
          col = cur_w;
          row = $urandom_range(0, cur_h);
        end else begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end
        send_cell(col, row);
        fed++;
      end
    end

    settle();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gmig_pkg.sv
rtl/core/gmig_front.sv
rtl/core/gmig_back.sv
rtl/core/gmig_outq.sv
rtl/core/grid_mesh_index_generator.sv
tb/sv/gmig_index_check.sv
tb/sv/testbench.sv
